@@ design/dph_pkg.sv @@
// ----------------------------------------------------------------------------
// dph_pkg: shared types and constants for direction to pitch/heading
// Fixed-point widths, CORDIC arctangent table and the request structs.
// ----------------------------------------------------------------------------
package dph_pkg;

    // input coordinate and angle formats
    localparam int COORD_W    = 16;
    localparam int ANGLE_FRAC = 6;
    localparam int INT_FRAC   = 16;               // internal angle: 2^-16 degree
    localparam int PRE_SHIFT  = 60 - COORD_W;

    // CORDIC gain in Q20, applied to |x| before chain P
    localparam int GAIN_W   = 21;
    localparam logic [GAIN_W-1:0] GAIN_Q20 = GAIN_W'(1726753);
    localparam int PROD_W   = COORD_W + GAIN_W;
    localparam int BX_SHIFT = PRE_SHIFT - 20;

    // datapath widths
    localparam int DATA_W    = 63;                // vector components, signed
    localparam int ANG_W     = 24;                // running angle, signed
    localparam int CANG_W    = 23;                // clamped angle, unsigned
    localparam int HEAD_W    = 25;                // folded heading, unsigned
    localparam int PITCH_W   = 14;
    localparam int HEADING_W = 15;
    localparam int ROUND_SHIFT = INT_FRAC - ANGLE_FRAC;
    localparam int PR_W      = CANG_W + 1 - ROUND_SHIFT;
    localparam int HR_W      = HEAD_W + 1 - ROUND_SHIFT;

    localparam logic [CANG_W-1:0] ANGLE_LIMIT = CANG_W'(90 << INT_FRAC);
    localparam logic [HEAD_W-1:0] HALF_TURN   = HEAD_W'(180 << INT_FRAC);
    localparam logic [HEAD_W-1:0] FULL_TURN   = HEAD_W'(360 << INT_FRAC);
    localparam logic [HR_W-1:0]   FULL_TURN_OUT = HR_W'(360 << ANGLE_FRAC);
    localparam logic [CANG_W:0]   ROUND_HALF_C = (CANG_W+1)'(1 << (ROUND_SHIFT - 1));
    localparam logic [HEAD_W:0]   ROUND_HALF_H = (HEAD_W+1)'(1 << (ROUND_SHIFT - 1));

    // round(atan(2^-i) * 180/pi * 2^16)
    localparam int ATAN_W = 22;
    localparam logic [ATAN_W-1:0] ATAN_DEG [32] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } dph_vec_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic [HEADING_W-1:0]      heading;
        logic                      degenerate;
    } dph_angle_t;

    // sideband carried along the CORDIC chains
    typedef struct packed {
        logic                    x_neg;
        logic                    y_neg;
        logic                    z_neg;
        logic                    degen;
        logic [PROD_W-1:0]       prod;   // |x| * gain, used at chain P entry
        logic signed [ANG_W-1:0] t;      // chain H angle, valid in chain P
    } dph_side_t;

endpackage

@@ design/direction_to_pitch_heading_top.sv @@
// ----------------------------------------------------------------------------
// direction_to_pitch_heading_top: 3-D direction to pitch and heading
// Two pipelined CORDIC vectoring chains turn (x up, y north, z east) into
// elevation and azimuth in 1/64 degree.
// ----------------------------------------------------------------------------
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+---------------------------------
//  vec     | vec_valid    | vec_stall    | dph_vec_t   {dir_x, dir_y, dir_z}
//  angle   | angle_valid  | angle_stall  | dph_angle_t {pitch, heading,
//          |              |              |              degenerate}
//
//  Throughput: one request per cycle, no gaps, while the pipe is not stalled.
//  Stages in order: prep, chain H, chain P, clamp/fold, round/output;
//  the depth of both CORDIC chains is set by CORDIC_STAGES.
//  Reset clears only the valid bits; no clearing pass, no state between items.
//  Stall: the whole pipe holds when a result sits in the output register and
//  angle_stall is high; vec_stall follows that same condition.
//
module direction_to_pitch_heading_top #(
    parameter int CORDIC_STAGES = 16      // 8..32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vec_valid,
    output logic                vec_stall,
    input  dph_pkg::dph_vec_t   vec,
    output logic                angle_valid,
    input  logic                angle_stall,
    output dph_pkg::dph_angle_t angle
);

    localparam int PAD_W = dph_pkg::DATA_W - dph_pkg::PROD_W - dph_pkg::BX_SHIFT;

    // global advance: stop only when the result register is full and held
    logic en;
    assign en        = !(angle_valid && angle_stall);
    assign vec_stall = !en;

    // chain H: vectoring on (|y|, |z|) -> heading base angle
    logic                              h_valid [CORDIC_STAGES+1];
    logic signed [dph_pkg::DATA_W-1:0] h_p     [CORDIC_STAGES+1];
    logic signed [dph_pkg::DATA_W-1:0] h_q     [CORDIC_STAGES+1];
    logic signed [dph_pkg::ANG_W-1:0]  h_ang   [CORDIC_STAGES+1];
    dph_pkg::dph_side_t                h_side  [CORDIC_STAGES+1];

    // chain P: vectoring on (horizontal magnitude, gain-scaled |x|) -> pitch
    logic                              p_valid [CORDIC_STAGES+1];
    logic signed [dph_pkg::DATA_W-1:0] p_p     [CORDIC_STAGES+1];
    logic signed [dph_pkg::DATA_W-1:0] p_q     [CORDIC_STAGES+1];
    logic signed [dph_pkg::ANG_W-1:0]  p_ang   [CORDIC_STAGES+1];
    dph_pkg::dph_side_t                p_side  [CORDIC_STAGES+1];

    dph_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (vec_valid),
        .vec       (vec),
        .valid_reg (h_valid[0]),
        .p_reg     (h_p[0]),
        .q_reg     (h_q[0]),
        .side_reg  (h_side[0])
    );
    assign h_ang[0] = '0;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_chain_h
        dph_cordic_stage #(
            .SHIFT (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid     (h_valid[i]),
            .p         (h_p[i]),
            .q         (h_q[i]),
            .ang       (h_ang[i]),
            .side      (h_side[i]),
            .valid_reg (h_valid[i+1]),
            .p_reg     (h_p[i+1]),
            .q_reg     (h_q[i+1]),
            .ang_reg   (h_ang[i+1]),
            .side_reg  (h_side[i+1])
        );
    end

    // chain P entry: magnitude from chain H, |x| scaled by the CORDIC gain;
    // the heading angle rides in the sideband
    always_comb
    begin
        p_valid[0]  = h_valid[CORDIC_STAGES];
        p_p[0]      = h_p[CORDIC_STAGES];
        p_q[0]      = signed'({{PAD_W{1'b0}}, h_side[CORDIC_STAGES].prod,
                               {dph_pkg::BX_SHIFT{1'b0}}});
        p_ang[0]    = '0;
        p_side[0]   = h_side[CORDIC_STAGES];
        p_side[0].t = h_ang[CORDIC_STAGES];
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_chain_p
        dph_cordic_stage #(
            .SHIFT (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid     (p_valid[i]),
            .p         (p_p[i]),
            .q         (p_q[i]),
            .ang       (p_ang[i]),
            .side      (p_side[i]),
            .valid_reg (p_valid[i+1]),
            .p_reg     (p_p[i+1]),
            .q_reg     (p_q[i+1]),
            .ang_reg   (p_ang[i+1]),
            .side_reg  (p_side[i+1])
        );
    end

    // clamp, fold into quadrant, round; output register lives here
    dph_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (p_valid[CORDIC_STAGES]),
        .ang       (p_ang[CORDIC_STAGES]),
        .side      (p_side[CORDIC_STAGES]),
        .valid_reg (angle_valid),
        .angle_reg (angle)
    );

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // a held result must back up to the input side
    a_stall_backpressure: assert property (
        @(posedge clk) disable iff (!rst_n)
        (angle_valid && angle_stall) |-> vec_stall
    ) else $error("held result did not stall the input");

    // degenerate result carries zero angles
    a_degen_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (angle_valid && angle.degenerate) |-> (angle.pitch == '0 && angle.heading == '0)
    ) else $error("degenerate result with nonzero angle");

    // result angles stay within their ranges
    a_angle_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        angle_valid |-> (angle.heading < 15'd23040
                         && angle.pitch <= 14'sd5760 && angle.pitch >= -14'sd5760)
    ) else $error("result angle out of range");

    // the chain P entry valid bit holds still under stall
    a_stall_freeze: assert property (
        @(posedge clk) disable iff (!rst_n)
        (angle_valid && angle_stall) |=> $stable(p_valid[0])
    ) else $error("pipeline moved during stall");

endmodule

@@ design/dph_prep.sv @@
// ----------------------------------------------------------------------------
// dph_prep: input stage
// Magnitudes, sign flags, degenerate detect and the |x| gain product.
// ----------------------------------------------------------------------------
module dph_prep (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              valid,
    input  dph_pkg::dph_vec_t                 vec,
    output logic                              valid_reg,
    output logic signed [dph_pkg::DATA_W-1:0] p_reg,
    output logic signed [dph_pkg::DATA_W-1:0] q_reg,
    output dph_pkg::dph_side_t                side_reg
);

    localparam int PAD_W = dph_pkg::DATA_W - dph_pkg::COORD_W - dph_pkg::PRE_SHIFT;

    logic [dph_pkg::COORD_W-1:0]      ax;
    logic [dph_pkg::COORD_W-1:0]      ay;
    logic [dph_pkg::COORD_W-1:0]      az;
    logic signed [dph_pkg::DATA_W-1:0] p_next;
    logic signed [dph_pkg::DATA_W-1:0] q_next;
    dph_pkg::dph_side_t               side_next;

    // two's complement magnitude; -2^15 maps to 2^15 as unsigned
    assign ax = vec.dir_x[dph_pkg::COORD_W-1] ? dph_pkg::COORD_W'(-vec.dir_x) : vec.dir_x;
    assign ay = vec.dir_y[dph_pkg::COORD_W-1] ? dph_pkg::COORD_W'(-vec.dir_y) : vec.dir_y;
    assign az = vec.dir_z[dph_pkg::COORD_W-1] ? dph_pkg::COORD_W'(-vec.dir_z) : vec.dir_z;

    always_comb
    begin
        p_next = signed'({{PAD_W{1'b0}}, ay, {dph_pkg::PRE_SHIFT{1'b0}}});
        q_next = signed'({{PAD_W{1'b0}}, az, {dph_pkg::PRE_SHIFT{1'b0}}});
        side_next.x_neg = vec.dir_x[dph_pkg::COORD_W-1];
        side_next.y_neg = vec.dir_y[dph_pkg::COORD_W-1];
        side_next.z_neg = vec.dir_z[dph_pkg::COORD_W-1];
        side_next.degen = (vec.dir_y == '0) && (vec.dir_z == '0);
        side_next.prod  = dph_pkg::PROD_W'(ax) * dph_pkg::PROD_W'(dph_pkg::GAIN_Q20);
        side_next.t     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            q_reg    <= q_next;
            side_reg <= side_next;
        end
    end

endmodule

@@ design/dph_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// dph_cordic_stage: one registered CORDIC vectoring iteration
// Drives q toward zero; accumulates the arctangent of 2^-SHIFT.
// ----------------------------------------------------------------------------
module dph_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              valid,
    input  logic signed [dph_pkg::DATA_W-1:0] p,
    input  logic signed [dph_pkg::DATA_W-1:0] q,
    input  logic signed [dph_pkg::ANG_W-1:0]  ang,
    input  dph_pkg::dph_side_t                side,
    output logic                              valid_reg,
    output logic signed [dph_pkg::DATA_W-1:0] p_reg,
    output logic signed [dph_pkg::DATA_W-1:0] q_reg,
    output logic signed [dph_pkg::ANG_W-1:0]  ang_reg,
    output dph_pkg::dph_side_t                side_reg
);

    localparam logic signed [dph_pkg::ANG_W-1:0] ATAN =
        signed'(dph_pkg::ANG_W'(dph_pkg::ATAN_DEG[SHIFT % 32]));

    logic signed [dph_pkg::DATA_W-1:0] dp;
    logic signed [dph_pkg::DATA_W-1:0] dq;
    logic signed [dph_pkg::DATA_W-1:0] p_next;
    logic signed [dph_pkg::DATA_W-1:0] q_next;
    logic signed [dph_pkg::ANG_W-1:0]  ang_next;

    // arithmetic shift = floor
    assign dp = q >>> SHIFT;
    assign dq = p >>> SHIFT;

    always_comb
    begin
        if (!q[dph_pkg::DATA_W-1])
        begin
            p_next   = p + dp;
            q_next   = q - dq;
            ang_next = ang + ATAN;
        end
        else
        begin
            p_next   = p - dp;
            q_next   = q + dq;
            ang_next = ang - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            q_reg    <= q_next;
            ang_reg  <= ang_next;
            side_reg <= side;
        end
    end

endmodule

@@ design/dph_finish.sv @@
// ----------------------------------------------------------------------------
// dph_finish: clamp, quadrant fold, rounding and output register
// Two stages: clamp/fold, then round/sign/wrap into the result register.
// ----------------------------------------------------------------------------
module dph_finish (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             valid,
    input  logic signed [dph_pkg::ANG_W-1:0] ang,
    input  dph_pkg::dph_side_t               side,
    output logic                             valid_reg,
    output dph_pkg::dph_angle_t              angle_reg
);

    logic [dph_pkg::CANG_W-1:0] pc_next;
    logic [dph_pkg::CANG_W-1:0] tc;
    logic [dph_pkg::HEAD_W-1:0] h_fold;
    logic [dph_pkg::HEAD_W-1:0] h_next;

    logic                       mid_valid_reg;
    logic [dph_pkg::CANG_W-1:0] pc_reg;
    logic [dph_pkg::HEAD_W-1:0] h_reg;
    logic                       x_neg_reg;
    logic                       degen_reg;

    logic [dph_pkg::CANG_W:0]    pr_sum;
    logic [dph_pkg::PR_W-1:0]    pr_mag;
    logic [dph_pkg::HEAD_W:0]    hr_sum;
    logic [dph_pkg::HR_W-1:0]    hr_raw;
    logic [dph_pkg::HR_W-1:0]    hr_wrap;
    dph_pkg::dph_angle_t         angle_next;

    function automatic logic [dph_pkg::CANG_W-1:0] clamp_angle(
        input logic signed [dph_pkg::ANG_W-1:0] a
    );
        logic [dph_pkg::CANG_W-1:0] r;
        if (a[dph_pkg::ANG_W-1])
            r = '0;
        else if (a[dph_pkg::CANG_W-1:0] > dph_pkg::ANGLE_LIMIT)
            r = dph_pkg::ANGLE_LIMIT;
        else
            r = a[dph_pkg::CANG_W-1:0];
        return r;
    endfunction

    // stage 1: clamp both chains, fold heading into its quadrant
    always_comb
    begin
        pc_next = clamp_angle(ang);
        tc      = clamp_angle(side.t);
        h_fold  = side.y_neg ? dph_pkg::HALF_TURN - dph_pkg::HEAD_W'(tc)
                             : dph_pkg::HEAD_W'(tc);
        h_next  = side.z_neg ? dph_pkg::FULL_TURN - h_fold : h_fold;
    end

    // stage 2: round half up, sign pitch, wrap heading at a full turn; zero both if degenerate
    always_comb
    begin
        pr_sum  = {1'b0, pc_reg} + dph_pkg::ROUND_HALF_C;
        pr_mag  = pr_sum[dph_pkg::ROUND_SHIFT +: dph_pkg::PR_W];
        hr_sum  = {1'b0, h_reg} + dph_pkg::ROUND_HALF_H;
        hr_raw  = hr_sum[dph_pkg::ROUND_SHIFT +: dph_pkg::HR_W];
        hr_wrap = (hr_raw >= dph_pkg::FULL_TURN_OUT) ? hr_raw - dph_pkg::FULL_TURN_OUT
                                                     : hr_raw;
        if (degen_reg)
        begin
            angle_next.pitch      = '0;
            angle_next.heading    = '0;
            angle_next.degenerate = 1'b1;
        end
        else
        begin
            angle_next.pitch      = x_neg_reg ? -signed'(dph_pkg::PITCH_W'(pr_mag))
                                              : signed'(dph_pkg::PITCH_W'(pr_mag));
            angle_next.heading    = hr_wrap[dph_pkg::HEADING_W-1:0];
            angle_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= valid;
            valid_reg     <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_reg    <= pc_next;
            h_reg     <= h_next;
            x_neg_reg <= side.x_neg;
            degen_reg <= side.degen;
            angle_reg <= angle_next;
        end
    end

endmodule

@@ dv/direction_to_pitch_heading_top_tb.sv @@
// ----------------------------------------------------------------------------
// direction_to_pitch_heading_top_tb: self-checking bench for pitch/heading
// Sends direction vectors over the vec channel and predicts each angle result
// with a bit-exact CORDIC model kept in this file. Every result on the angle
// channel is checked field by field against the oldest pending prediction.
// Directed vectors come first, then random ones under four idle/stall mixes.
// ----------------------------------------------------------------------------
module direction_to_pitch_heading_top_tb;

    localparam int     CORDIC_DEPTH = 16;
    localparam int     PIPE_LATENCY = 2 * CORDIC_DEPTH + 3;
    localparam int     TIMEOUT_CYC  = 200000;

    // angle arithmetic: 2^-16 degree inside, 2^-6 degree at the output
    localparam int     FINE_BITS    = 16;
    localparam int     OUT_BITS     = 6;
    localparam int     FRAC_DROP    = FINE_BITS - OUT_BITS;
    localparam longint RIGHT_ANGLE  = 90 * 65536;
    localparam longint HALF_CIRCLE  = 180 * 65536;
    localparam longint FULL_CIRCLE  = 360 * 65536;
    localparam longint CIRCLE_OUT   = 360 * 64;
    localparam int     MAG_SHIFT    = 60 - 16;      // pre-shift of |y|, |z|
    localparam int     UP_SHIFT     = MAG_SHIFT - 20;
    localparam longint GAIN_Q20_TB  = 1726753;      // CORDIC gain, Q20

    // atan(2^-i) in 2^-16 degree
    localparam longint ARCTAN_DEG [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                vec_valid   = 1'b0;
    logic                vec_stall;
    dph_pkg::dph_vec_t   vec         = '0;
    logic                angle_valid;
    logic                angle_stall = 1'b0;
    dph_pkg::dph_angle_t angle;

    dph_pkg::dph_angle_t expected_angles [$];
    dph_pkg::dph_vec_t   sent_vecs [$];
    int                  fail_count    = 0;
    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;

    direction_to_pitch_heading_top #(
        .CORDIC_STAGES (CORDIC_DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .vec_valid   (vec_valid),
        .vec_stall   (vec_stall),
        .vec         (vec),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .angle       (angle)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // First-quadrant vectoring; returns the clamped angle, mag_out gets the
    // final first component. Arithmetic shifts on longint floor as needed.
    function automatic longint cordic_vector(input longint a_in, input longint b_in,
                                             output longint mag_out);
        longint a;
        longint b;
        longint da;
        longint db;
        longint ang;
        int     i;
        a   = a_in;
        b   = b_in;
        ang = 0;
        for (i = 0; i < CORDIC_DEPTH; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0)
            begin
                a   = a + da;
                b   = b - db;
                ang = ang + ARCTAN_DEG[i];
            end
            else
            begin
                a   = a - da;
                b   = b + db;
                ang = ang - ARCTAN_DEG[i];
            end
        end
        mag_out = a;
        if (ang < 0)
            ang = 0;
        if (ang > RIGHT_ANGLE)
            ang = RIGHT_ANGLE;
        return ang;
    endfunction

    function automatic dph_pkg::dph_angle_t predict_angles(input dph_pkg::dph_vec_t v);
        longint              x;
        longint              y;
        longint              z;
        longint              mag_h;
        longint              mag_p;
        longint              t;
        longint              p;
        longint              h;
        longint              pr;
        longint              hr;
        dph_pkg::dph_angle_t r;
        x = v.dir_x;
        y = v.dir_y;
        z = v.dir_z;
        r = '0;
        // no horizontal projection: flag it, both angles zero
        if (y == 0 && z == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        // heading chain on (|y|, |z|), pitch chain on (magnitude, |x| * gain)
        t = cordic_vector((y < 0 ? -y : y) <<< MAG_SHIFT,
                          (z < 0 ? -z : z) <<< MAG_SHIFT, mag_h);
        p = cordic_vector(mag_h, ((x < 0 ? -x : x) <<< UP_SHIFT) * GAIN_Q20_TB, mag_p);

        pr = (p + (64'sd1 <<< (FRAC_DROP - 1))) >>> FRAC_DROP;
        if (x < 0)
            pr = -pr;

        h = t;
        if (y < 0)
            h = HALF_CIRCLE - h;
        if (z < 0)
            h = FULL_CIRCLE - h;
        hr = (h + (64'sd1 <<< (FRAC_DROP - 1))) >>> FRAC_DROP;
        if (hr >= CIRCLE_OUT)
            hr = hr - CIRCLE_OUT;   // just under 360 rounds up: wrap to 0

        r.pitch   = pr[dph_pkg::PITCH_W-1:0];
        r.heading = hr[dph_pkg::HEADING_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    function automatic logic signed [dph_pkg::COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2, 3:    return dph_pkg::COORD_W'(int'($urandom_range(0, 8)) - 4);
            4:       return dph_pkg::COORD_W'(int'($urandom_range(0, 512)) - 256);
            default: return dph_pkg::COORD_W'($urandom());
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    // While idle the payload is scrambled since valid is low.
    task automatic send_vec(input dph_pkg::dph_vec_t v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            vec_valid <= 1'b0;
            vec       <= dph_pkg::dph_vec_t'({$urandom(), $urandom()});
            @(posedge clk);
        end
        vec_valid <= 1'b1;
        vec       <= v;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        expected_angles.push_back(predict_angles(v));
        sent_vecs.push_back(v);
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        dph_pkg::dph_vec_t v;
        v.dir_x = dph_pkg::COORD_W'(x);
        v.dir_y = dph_pkg::COORD_W'(y);
        v.dir_z = dph_pkg::COORD_W'(z);
        send_vec(v);
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall and result checking
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
            angle_stall <= 1'b0;
        else
            angle_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_angles
        dph_pkg::dph_angle_t want;
        dph_pkg::dph_vec_t   src;
        if (rst_n && angle_valid && !angle_stall)
        begin
            if (expected_angles.size() == 0)
            begin
                $error("angle result %h with no request outstanding", angle);
                fail_count++;
            end
            else
            begin
                want = expected_angles.pop_front();
                src  = sent_vecs.pop_front();
                if (angle.pitch !== want.pitch)
                begin
                    $error("pitch: expected %0d, got %0d (x %0d y %0d z %0d)",
                           want.pitch, angle.pitch, src.dir_x, src.dir_y, src.dir_z);
                    fail_count++;
                end
                if (angle.heading !== want.heading)
                begin
                    $error("heading: expected %0d, got %0d (x %0d y %0d z %0d)",
                           want.heading, angle.heading, src.dir_x, src.dir_y, src.dir_z);
                    fail_count++;
                end
                if (angle.degenerate !== want.degenerate)
                begin
                    $error("degenerate: expected %0b, got %0b (x %0d y %0d z %0d)",
                           want.degenerate, angle.degenerate,
                           src.dir_x, src.dir_y, src.dir_z);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // zero horizontal projection, any x including zero
    task automatic test_degenerate();
        send_xyz(0, 0, 0);
        send_xyz(32767, 0, 0);
        send_xyz(-32768, 0, 0);
        send_xyz(-1, 0, 0);
    endtask

    // the four compass points, near-vertical, and heading just under 360
    task automatic test_cardinal();
        send_xyz(0, 100, 0);
        send_xyz(0, -100, 0);
        send_xyz(0, 0, 100);
        send_xyz(0, 0, -100);
        send_xyz(32767, 1, 0);
        send_xyz(-32768, 0, 1);
        send_xyz(0, 32767, -1);     // rounds to 360, wraps to 0
        send_xyz(5, -32768, -1);
    endtask

    // corners and edges of the coordinate range, and tiny vectors near zero
    task automatic test_extremes();
        send_xyz(-32768, -32768, -32768);
        send_xyz(32767, 32767, 32767);
        send_xyz(-32768, 32767, -32768);
        send_xyz(32767, -32768, 1);
        send_xyz(-1, -1, -1);
        send_xyz(1, 1, 1);
        send_xyz(32767, 0, -32768);
        send_xyz(-32768, -1, 32767);
    endtask

    task automatic test_random(input int count, input int idle_pct, input int hold_pct);
        dph_pkg::dph_vec_t v;
        int                k;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        for (k = 0; k < count; k++)
        begin
            v.dir_x = random_coord();
            v.dir_y = random_coord();
            v.dir_z = random_coord();
            if ($urandom_range(0, 19) == 0)
            begin
                v.dir_y = '0;
                v.dir_z = '0;
            end
            send_vec(v);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate();
        test_cardinal();
        test_extremes();
        test_random(258, 0, 0);
        test_random(258, 71, 0);
        test_random(258, 0, 71);
        test_random(258, 14, 14);

        vec_valid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 16) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(12 * TIMEOUT_CYC);
        $display("TB_ERROR");
        $finish;
    end

endmodule
